@@ rtl/core/rvd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rvd_pkg;

  // Field and register widths
  localparam int COORD_BITS     = 12;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int CENTER_W       = 14;
  localparam int INV_W          = 32;
  localparam int RATIO_IN_W     = 17;
  localparam int RATIO_IN_FRAC  = 16;
  localparam int CH_W           = 8;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 4;

  // Distance datapath
  localparam int DIST_FRAC_BITS = 8;
  localparam int PROD_FRAC_BITS = DIST_FRAC_BITS + INV_W;
  localparam int DIFF_W = ((COORD_BITS > CENTER_W - 1) ? COORD_BITS : CENTER_W - 1) + 2;
  localparam int SQ_W   = 2 * (DIFF_W - 1);
  localparam int SUM_W  = SQ_W + 1;
  localparam int RAD_W  = SUM_W + 2 * DIST_FRAC_BITS;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int RAD_E  = 2 * ROOT_W;

  // Gain datapath
  localparam int PROD_W      = ROOT_W + INV_W;
  localparam int TERM_SHIFT  = PROD_FRAC_BITS - GAIN_FRAC_BITS;
  localparam int TERM_W      = PROD_W + 1 - TERM_SHIFT;
  localparam int RATIO_W     = GAIN_FRAC_BITS + 1;
  localparam int ALIGN_W     = RATIO_IN_W + PROD_FRAC_BITS - RATIO_IN_FRAC;
  localparam int GAIN_W      = ((TERM_W > RATIO_W) ? TERM_W : RATIO_W) + 1;
  localparam int MUL_W       = CH_W + RATIO_W + 1;
  localparam int SCALE_W     = MUL_W - GAIN_FRAC_BITS;

  localparam logic [RATIO_IN_W-1:0] RATIO_RESET = RATIO_IN_W'(58982);

  typedef logic [CH_W-1:0] chan_t;
  typedef logic signed [CENTER_W-1:0] center_t;
  typedef logic [RAD_E-1:0] rad_t;
  typedef logic [ROOT_W-1:0] root_t;

  typedef enum logic [1:0] {
    REG_CENTER_X   = 2'd0,
    REG_CENTER_Y   = 2'd1,
    REG_INV_RADIUS = 2'd2,
    REG_GAIN_RATIO = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    chan_t                 blue_in;
    chan_t                 green_in;
    chan_t                 red_in;
  } pixel_in_t;

  typedef struct packed {
    chan_t blue_out;
    chan_t green_out;
    chan_t red_out;
  } pixel_out_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pix_t;

  typedef struct packed {
    center_t                 center_x;
    center_t                 center_y;
    logic [INV_W-1:0]        inv_radius;
    logic [RATIO_IN_W-1:0]   gain_ratio;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/rvd_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rvd_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rvd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rvd_pkg::DATA_W-1:0] pwdata,
  output logic      [rvd_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output rvd_pkg::cfg_t                   cfg
);

  rvd_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = rvd_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x   <= '0;
      cfg.center_y   <= '0;
      cfg.inv_radius <= '0;
      cfg.gain_ratio <= rvd_pkg::RATIO_RESET;
    end else if (wr) begin
      case (idx)
        rvd_pkg::REG_CENTER_X:   cfg.center_x   <= pwdata[rvd_pkg::CENTER_W-1:0];
        rvd_pkg::REG_CENTER_Y:   cfg.center_y   <= pwdata[rvd_pkg::CENTER_W-1:0];
        rvd_pkg::REG_INV_RADIUS: cfg.inv_radius <= pwdata[rvd_pkg::INV_W-1:0];
        rvd_pkg::REG_GAIN_RATIO: cfg.gain_ratio <= pwdata[rvd_pkg::RATIO_IN_W-1:0];
        default: ;
      endcase
    end
  end

  // Readback
  always_comb begin
    case (idx)
      rvd_pkg::REG_CENTER_X:   prdata = rvd_pkg::DATA_W'(cfg.center_x);
      rvd_pkg::REG_CENTER_Y:   prdata = rvd_pkg::DATA_W'(cfg.center_y);
      rvd_pkg::REG_INV_RADIUS: prdata = rvd_pkg::DATA_W'(cfg.inv_radius);
      rvd_pkg::REG_GAIN_RATIO: prdata = rvd_pkg::DATA_W'(cfg.gain_ratio);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/rvd_geom.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Offset, square and sum: three stages from pixel position to radicand
module rvd_geom (
  input  wire logic               clk,
  input  wire logic               rst,
  input  rvd_pkg::cfg_t           cfg,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  rvd_pkg::pixel_in_t      in_beat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rvd_pkg::rad_t           out_rad,
  output rvd_pkg::pix_t           out_pix
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic signed [rvd_pkg::DIFF_W-1:0]   dx, dy;
  logic signed [2*rvd_pkg::DIFF_W-1:0] px, py;
  logic [rvd_pkg::SQ_W-1:0]            sqx, sqy;
  logic [rvd_pkg::SUM_W-1:0]           sum;
  rvd_pkg::pix_t                       pix1, pix2;

  // Bubble-collapsing ready chain
  assign rdy3     = ~v3 | ~out_stall;
  assign rdy2     = ~v2 | rdy3;
  assign rdy1     = ~v1 | rdy2;
  assign in_stall = ~rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1: offsets from the center
  always_ff @(posedge clk) begin
    if (rdy1) begin
      dx   <= rvd_pkg::DIFF_W'($signed({1'b0, in_beat.pixel_x}))
            - rvd_pkg::DIFF_W'(cfg.center_x);
      dy   <= rvd_pkg::DIFF_W'($signed({1'b0, in_beat.pixel_y}))
            - rvd_pkg::DIFF_W'(cfg.center_y);
      pix1 <= '{blue: in_beat.blue_in, green: in_beat.green_in, red: in_beat.red_in};
    end
  end

  // Stage 2: squares
  assign px = dx * dx;
  assign py = dy * dy;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sqx  <= px[rvd_pkg::SQ_W-1:0];
      sqy  <= py[rvd_pkg::SQ_W-1:0];
      pix2 <= pix1;
    end
  end

  // Stage 3: sum, scaled for the distance fraction bits
  assign sum = rvd_pkg::SUM_W'(sqx) + rvd_pkg::SUM_W'(sqy);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_rad <= rvd_pkg::RAD_E'({sum, {(2*rvd_pkg::DIST_FRAC_BITS){1'b0}}});
      out_pix <= pix2;
    end
  end

  assign out_valid = v3;

endmodule

`default_nettype wire

@@ rtl/core/rvd_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring square root, one result bit per stage, MSB first
module rvd_sqrt (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  rvd_pkg::rad_t   in_rad,
  input  rvd_pkg::pix_t   in_pix,
  output logic            out_valid,
  input  wire logic       out_stall,
  output rvd_pkg::root_t  out_root,
  output rvd_pkg::pix_t   out_pix
);

  localparam int N = rvd_pkg::ROOT_W;

  logic            vld_q  [N];
  logic            rdy    [N+1];
  rvd_pkg::root_t  root_q [N];
  rvd_pkg::pix_t   pix_q  [N];
  rvd_pkg::rad_t   rem_q  [N-1];

  assign rdy[N]    = ~vld_q[N-1] | ~out_stall;
  assign in_stall  = ~rdy[0];
  assign out_valid = vld_q[N-1];
  assign out_root  = root_q[N-1];
  assign out_pix   = pix_q[N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int BIT = N - 1 - k;

    logic                     vld_in;
    rvd_pkg::root_t           root_in;
    rvd_pkg::rad_t            rem_in;
    rvd_pkg::pix_t            pix_in;
    logic [rvd_pkg::RAD_E:0]  test;
    logic                     take;
    rvd_pkg::rad_t            rem_nx;
    rvd_pkg::root_t           root_nx;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign root_in = '0;
      assign rem_in  = in_rad;
      assign pix_in  = in_pix;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign pix_in  = pix_q[k-1];
    end

    assign rdy[k] = ~vld_q[k] | rdy[k+1];

    // (root + 2^BIT)^2 - root^2
    always_comb begin
      test    = ((rvd_pkg::RAD_E+1)'(root_in) << (BIT + 1))
              + ((rvd_pkg::RAD_E+1)'(1) << (2 * BIT));
      take    = {1'b0, rem_in} >= test;
      rem_nx  = take ? rvd_pkg::RAD_E'({1'b0, rem_in} - test) : rem_in;
      root_nx = take ? (root_in | (N'(1) << BIT)) : root_in;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        root_q[k] <= root_nx;
        pix_q[k]  <= pix_in;
      end
    end

    if (k < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          rem_q[k] <= rem_nx;
        end
      end
    end else begin : g_last
      // Final remainder is not needed
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rvd_shade.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Distance to gain, then per-channel scale and clamp into the output register
module rvd_shade (
  input  wire logic           clk,
  input  wire logic           rst,
  input  rvd_pkg::cfg_t       cfg,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  rvd_pkg::root_t      in_root,
  input  rvd_pkg::pix_t       in_pix,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rvd_pkg::pixel_out_t out_beat
);

  localparam int G = rvd_pkg::GAIN_FRAC_BITS;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic [rvd_pkg::PROD_W-1:0]  prod;
  logic [rvd_pkg::PROD_W:0]    rsum;
  logic [rvd_pkg::TERM_W-1:0]  term;
  logic [rvd_pkg::RATIO_W-1:0] ratio;
  logic [rvd_pkg::GAIN_W-1:0]  diff;
  logic                        gpos;
  logic [rvd_pkg::RATIO_W-1:0] gmag;
  rvd_pkg::pix_t               pix1, pix2;

  function automatic rvd_pkg::chan_t scale_ch(rvd_pkg::chan_t c,
                                              logic [rvd_pkg::RATIO_W-1:0] g,
                                              logic pos);
    logic [rvd_pkg::MUL_W-1:0]   p;
    logic [rvd_pkg::SCALE_W-1:0] q;
    p = rvd_pkg::MUL_W'(c) * rvd_pkg::MUL_W'(g) + (rvd_pkg::MUL_W'(1) << (G - 1));
    q = p[rvd_pkg::MUL_W-1:G];
    if (!pos) begin
      return '0;
    end else if (q > rvd_pkg::SCALE_W'(255)) begin
      return '1;
    end else begin
      return q[rvd_pkg::CH_W-1:0];
    end
  endfunction

  assign rdy3     = ~v3 | ~out_stall;
  assign rdy2     = ~v2 | rdy3;
  assign rdy1     = ~v1 | rdy2;
  assign in_stall = ~rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1: distance times inverse radius
  always_ff @(posedge clk) begin
    if (rdy1) begin
      prod <= rvd_pkg::PROD_W'(in_root) * rvd_pkg::PROD_W'(cfg.inv_radius);
      pix1 <= in_pix;
    end
  end

  // Stage 2: round the term half up, subtract from the aligned ratio
  always_comb begin
    rsum  = (rvd_pkg::PROD_W+1)'(prod)
          + ((rvd_pkg::PROD_W+1)'(1) << (rvd_pkg::TERM_SHIFT - 1));
    term  = rsum[rvd_pkg::PROD_W:rvd_pkg::TERM_SHIFT];
    ratio = rvd_pkg::RATIO_W'({cfg.gain_ratio,
             {(rvd_pkg::ALIGN_W-rvd_pkg::RATIO_IN_W){1'b0}}} >> rvd_pkg::TERM_SHIFT);
    diff  = rvd_pkg::GAIN_W'(ratio) - rvd_pkg::GAIN_W'(term);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      gpos <= ~diff[rvd_pkg::GAIN_W-1] & (|diff);
      gmag <= diff[rvd_pkg::RATIO_W-1:0];
      pix2 <= pix1;
    end
  end

  // Stage 3: scale each channel, round, clamp
  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_beat.blue_out  <= scale_ch(pix2.blue, gmag, gpos);
      out_beat.green_out <= scale_ch(pix2.green, gmag, gpos);
      out_beat.red_out   <= scale_ch(pix2.red, gmag, gpos);
    end
  end

  assign out_valid = v3;

endmodule

`default_nettype wire

@@ rtl/core/radial_vignette_darkening.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipeline from input beat to result beat:
//   three offset/square/sum stages, one square-root stage per distance bit, three gain stages.
// Throughput: one pixel per clock; every stage has its own valid bit, so bubbles collapse
//   and pixels keep entering while a result waits at the output, until all stages are full.
// Reset: synchronous, clears all valid bits and loads the register defaults
//   (center 0,0, inverse radius 0, gain ratio 0.9).
module radial_vignette_darkening (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       pixel_valid,
  output logic                            pixel_stall,
  input  rvd_pkg::pixel_in_t              pixel,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output rvd_pkg::pixel_out_t             result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rvd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rvd_pkg::DATA_W-1:0] pwdata,
  output logic      [rvd_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  rvd_pkg::cfg_t  cfg;
  logic           g_valid, g_stall;
  rvd_pkg::rad_t  g_rad;
  rvd_pkg::pix_t  g_pix;
  logic           s_valid, s_stall;
  rvd_pkg::root_t s_root;
  rvd_pkg::pix_t  s_pix;

  rvd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rvd_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pixel_valid),
    .in_stall  (pixel_stall),
    .in_beat   (pixel),
    .out_valid (g_valid),
    .out_stall (g_stall),
    .out_rad   (g_rad),
    .out_pix   (g_pix)
  );

  rvd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_stall  (g_stall),
    .in_rad    (g_rad),
    .in_pix    (g_pix),
    .out_valid (s_valid),
    .out_stall (s_stall),
    .out_root  (s_root),
    .out_pix   (s_pix)
  );

  rvd_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_valid),
    .in_stall  (s_stall),
    .in_root   (s_root),
    .in_pix    (s_pix),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_beat  (result)
  );

endmodule

`default_nettype wire

@@ rtl/core/rvd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rvd_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       pixel_stall,
  input wire logic                       result_valid,
  input wire logic                       result_stall,
  input rvd_pkg::pixel_out_t             result,
  input wire logic                       psel,
  input wire logic                       penable,
  input wire logic                       pwrite,
  input wire logic [rvd_pkg::ADDR_W-1:0] paddr,
  input wire logic [rvd_pkg::DATA_W-1:0] pwdata,
  input wire logic [rvd_pkg::DATA_W-1:0] prdata
);

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed under stall");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // With the output empty, every stage can move, so input is taken
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !pixel_stall)
    else $error("input stalled with an empty output");

  // Ready at the output ripples all the way to the input
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    !result_stall |-> !pixel_stall)
    else $error("input stalled while output is not");

  // Inverse radius reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[3:2] == rvd_pkg::REG_INV_RADIUS)
    ##1 (psel && !pwrite && paddr[3:2] == rvd_pkg::REG_INV_RADIUS)
    |-> prdata == $past(pwdata))
    else $error("inverse radius readback mismatch");

endmodule

bind radial_vignette_darkening rvd_checker u_rvd_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_stall  (pixel_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata)
);

`default_nettype wire
